// File: design/zx128_pkg.sv
// shared types and constants for the zx128 paging and port unit
package zx128_pkg;

  typedef enum logic [1:0] {
    CMD_MEM_RD = 2'd0,
    CMD_MEM_WR = 2'd1,
    CMD_IO_RD  = 2'd2,
    CMD_IO_WR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REGION_ROM   = 2'd0,
    REGION_RAM5  = 2'd1,
    REGION_RAM2  = 2'd2,
    REGION_BANKD = 2'd3
  } region_t;

  localparam logic [7:0] PORT_LO_ULA    = 8'hFE;
  localparam logic [7:0] PORT_LO_PAGING = 8'hFD;
  localparam logic [7:0] PORT_LO_JOY    = 8'h1F;
  localparam logic [7:0] PORT_HI_128    = 8'h7F;
  localparam logic [7:0] PORT_HI_PLUS3  = 8'h1F;
  localparam logic [7:0] PORT_HI_EAR    = 8'hFE;
  localparam logic [7:0] FLOATING_BUS   = 8'hA0;

  localparam logic [2:0] PAGE_RAM5      = 3'd5;
  localparam logic [2:0] PAGE_RAM2      = 3'd2;
  localparam logic [2:0] BORDER_RESET   = 3'd7;

  localparam int unsigned NUM_ROWS = 8;
  localparam int unsigned EAR_BIT  = 6;

endpackage

// File: design/zx128_ifs.sv
// valid/ready channel interfaces for the zx128 bus access and result words
interface zx128_in_if import zx128_pkg::*; ();
  logic        valid;
  logic        ready;
  cmd_t        cmd;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [63:0] key_rows;
  logic        ear_in;
  logic [7:0]  joystick;

  modport source (output valid, cmd, address, write_data, key_rows, ear_in, joystick,
                  input ready);
  modport sink   (input valid, cmd, address, write_data, key_rows, ear_in, joystick,
                  output ready);
endinterface

interface zx128_out_if;
  logic        valid;
  logic        ready;
  logic        is_rom;
  logic [2:0]  page;
  logic [13:0] offset;
  logic        mem_write_enable;
  logic [7:0]  io_read_data;
  logic [2:0]  border_colour;
  logic        speaker_out;
  logic        mic_out;
  logic        shadow_screen;
  logic        special_mode;

  modport source (output valid, is_rom, page, offset, mem_write_enable, io_read_data,
                  border_colour, speaker_out, mic_out, shadow_screen, special_mode,
                  input ready);
  modport sink   (input valid, is_rom, page, offset, mem_write_enable, io_read_data,
                  border_colour, speaker_out, mic_out, shadow_screen, special_mode,
                  output ready);
endinterface

// File: design/zx128_memory_paging_and_port_unit_core.sv
// top level of the zx128 memory paging and port unit
//
// in_ch carries one cpu bus access per word: memory read, memory write,
// io read or io write, with the key rows, ear level and joystick byte.
// out_ch carries one result word per access: rom/ram page and offset,
// the ram write strobe, the io read byte, and the border, speaker, mic,
// shadow screen and special mode bits as they stand after the access.
// the result word of an accepted access is registered and shows from the
// cycle after the access is accepted. throughput is one word per cycle
// while the receiver does not stall, set by the single result register;
// paging and port latches update at the edge that accepts the access.
// when the receiver stalls, the result word holds and in_ch.ready drops
// only while a held word is not being taken in the same cycle.
// reset (rst_n low, synchronous) empties the result register and sets all
// latches to zero except the border, which comes up white (7).
module zx128_memory_paging_and_port_unit_core
  import zx128_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  zx128_in_if.sink     in_ch,
  zx128_out_if.source  out_ch
);

  // paging and port latches
  logic [2:0] ram_bank_r,   ram_bank_nxt;
  logic       rom_sel_r,    rom_sel_nxt;
  logic       video_sel_r,  video_sel_nxt;
  logic       locked_r,     locked_nxt;
  logic       p3_mode_r,    p3_mode_nxt;
  logic       p3_rom_r,     p3_rom_nxt;
  logic [2:0] border_r,     border_nxt;
  logic       ear_r,        ear_nxt;
  logic       speaker_r,    speaker_nxt;
  logic       mic_r,        mic_nxt;

  // result register
  logic        out_valid_r;
  logic        is_rom_r,   is_rom_nxt;
  logic [2:0]  page_r,     page_nxt;
  logic [13:0] offset_r,   offset_nxt;
  logic        we_r,       we_nxt;
  logic [7:0]  rd_r,       rd_nxt;

  logic       in_fire;
  logic [7:0] port_lo;
  logic [7:0] port_hi;
  logic [7:0] key_acc;
  logic [7:0] row0;
  region_t    region;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign port_lo = in_ch.address[7:0];
  assign port_hi = in_ch.address[15:8];
  assign region  = region_t'(in_ch.address[15:14]);

  // ear is sampled only on a full ula port read with high byte FE
  always_comb begin
    ear_nxt = ear_r;
    if (in_ch.cmd == CMD_IO_RD && port_lo == PORT_LO_ULA && port_hi == PORT_HI_EAR) begin
      ear_nxt = in_ch.ear_in;
    end
  end

  // a row joins the and when its address line is low
  always_comb begin
    row0          = in_ch.key_rows[7:0];
    row0[EAR_BIT] = ear_nxt;
    key_acc       = 8'hFF;
    for (int n = 0; n < NUM_ROWS; n++) begin
      if (!port_hi[n]) begin
        if (n == 0) begin
          key_acc = key_acc & row0;
        end else begin
          key_acc = key_acc & in_ch.key_rows[8*n +: 8];
        end
      end
    end
  end

  always_comb begin
    ram_bank_nxt  = ram_bank_r;
    rom_sel_nxt   = rom_sel_r;
    video_sel_nxt = video_sel_r;
    locked_nxt    = locked_r;
    p3_mode_nxt   = p3_mode_r;
    p3_rom_nxt    = p3_rom_r;
    border_nxt    = border_r;
    speaker_nxt   = speaker_r;
    mic_nxt       = mic_r;
    is_rom_nxt    = 1'b0;
    page_nxt      = 3'd0;
    offset_nxt    = 14'd0;
    we_nxt        = 1'b0;
    rd_nxt        = 8'd0;

    case (in_ch.cmd)
      CMD_MEM_RD, CMD_MEM_WR: begin
        offset_nxt = in_ch.address[13:0];
        case (region)
          REGION_ROM: begin
            is_rom_nxt = 1'b1;
            page_nxt   = {1'b0, p3_rom_r, rom_sel_r};
          end
          REGION_RAM5: page_nxt = PAGE_RAM5;
          REGION_RAM2: page_nxt = PAGE_RAM2;
          default:     page_nxt = ram_bank_r;
        endcase
        // rom is write protected
        we_nxt = (in_ch.cmd == CMD_MEM_WR) && (region != REGION_ROM);
      end
      CMD_IO_RD: begin
        if (port_lo == PORT_LO_ULA) begin
          rd_nxt = key_acc;
        end else if (port_lo == PORT_LO_JOY) begin
          rd_nxt = in_ch.joystick;
        end else begin
          rd_nxt = FLOATING_BUS;
        end
      end
      CMD_IO_WR: begin
        if (port_lo == PORT_LO_ULA) begin
          border_nxt  = in_ch.write_data[2:0];
          mic_nxt     = in_ch.write_data[3];
          speaker_nxt = in_ch.write_data[4];
        end else if (port_lo == PORT_LO_PAGING) begin
          if (port_hi == PORT_HI_128) begin
            // lock holds until reset
            if (!locked_r) begin
              ram_bank_nxt  = in_ch.write_data[2:0];
              video_sel_nxt = in_ch.write_data[3];
              rom_sel_nxt   = in_ch.write_data[4];
              locked_nxt    = in_ch.write_data[5];
            end
          end else if (port_hi == PORT_HI_PLUS3) begin
            p3_mode_nxt = in_ch.write_data[0];
            p3_rom_nxt  = in_ch.write_data[2];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ram_bank_r  <= 3'd0;
      rom_sel_r   <= 1'b0;
      video_sel_r <= 1'b0;
      locked_r    <= 1'b0;
      p3_mode_r   <= 1'b0;
      p3_rom_r    <= 1'b0;
      border_r    <= BORDER_RESET;
      ear_r       <= 1'b0;
      speaker_r   <= 1'b0;
      mic_r       <= 1'b0;
    end else begin
      if (in_fire) begin
        out_valid_r <= 1'b1;
        ram_bank_r  <= ram_bank_nxt;
        rom_sel_r   <= rom_sel_nxt;
        video_sel_r <= video_sel_nxt;
        locked_r    <= locked_nxt;
        p3_mode_r   <= p3_mode_nxt;
        p3_rom_r    <= p3_rom_nxt;
        border_r    <= border_nxt;
        ear_r       <= ear_nxt;
        speaker_r   <= speaker_nxt;
        mic_r       <= mic_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      is_rom_r <= is_rom_nxt;
      page_r   <= page_nxt;
      offset_r <= offset_nxt;
      we_r     <= we_nxt;
      rd_r     <= rd_nxt;
    end
  end

  // latch outputs track the state as left by the word in the result register
  assign out_ch.valid            = out_valid_r;
  assign out_ch.is_rom           = is_rom_r;
  assign out_ch.page             = page_r;
  assign out_ch.offset           = offset_r;
  assign out_ch.mem_write_enable = we_r;
  assign out_ch.io_read_data     = rd_r;
  assign out_ch.border_colour    = border_r;
  assign out_ch.speaker_out      = speaker_r;
  assign out_ch.mic_out          = mic_r;
  assign out_ch.shadow_screen    = video_sel_r;
  assign out_ch.special_mode     = p3_mode_r;

endmodule
